// ----- rtl/rgbsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rgbsc_pkg;

   // fixed field widths
   localparam int SLOT_W  = 7;
   localparam int DIV_W   = 4;
   localparam int LEVEL_W = 7;
   localparam int POS_W   = 7;
   localparam int ROM_LEN = 72;
   localparam int ROM_IDX_W = $clog2(ROM_LEN);
   localparam int WRAP_W  = POS_W + 1;

   localparam logic [DIV_W-1:0] FPS_RESET = DIV_W'(5);

   // floor(50 + 50*sin(5*i degrees))
   localparam logic [LEVEL_W-1:0] SINE_ROM [0:ROM_LEN-1] = '{
      7'd50, 7'd54, 7'd58, 7'd62, 7'd67, 7'd71, 7'd75, 7'd78, 7'd82,
      7'd85, 7'd88, 7'd90, 7'd93, 7'd95, 7'd96, 7'd98, 7'd99, 7'd99,
      7'd100, 7'd99, 7'd99, 7'd98, 7'd96, 7'd95, 7'd93, 7'd90, 7'd88,
      7'd85, 7'd82, 7'd78, 7'd75, 7'd71, 7'd67, 7'd62, 7'd58, 7'd54,
      7'd50, 7'd45, 7'd41, 7'd37, 7'd32, 7'd28, 7'd25, 7'd21, 7'd17,
      7'd14, 7'd11, 7'd9, 7'd6, 7'd4, 7'd3, 7'd1, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd1, 7'd3, 7'd4, 7'd6, 7'd9, 7'd11,
      7'd14, 7'd17, 7'd21, 7'd25, 7'd28, 7'd32, 7'd37, 7'd41, 7'd45
   };

   // channel state seen by the output stage
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [POS_W-1:0]   pos;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] green;
   } phase_state_type;

   // ROM read with the index folded into the 72-entry period
   function automatic logic [LEVEL_W-1:0] rom_at(input logic [WRAP_W-1:0] idx);
      logic [WRAP_W-1:0] folded;
      folded = (idx >= WRAP_W'(ROM_LEN)) ? idx - WRAP_W'(ROM_LEN) : idx;
      return SINE_ROM[folded[ROM_IDX_W-1:0]];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rgbsc_phase.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rgbsc_phase
   import rgbsc_pkg::*;
#(
   parameter int PERIOD     = 100,
   parameter int TABLE_SIZE = 72
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             csr_wr_en,
   input  wire logic [DIV_W-1:0] csr_wr_data,
   output phase_state_type       state
);

   localparam logic [WRAP_W-1:0] OFS_B = WRAP_W'(TABLE_SIZE / 3);
   localparam logic [WRAP_W-1:0] OFS_G = WRAP_W'(2 * TABLE_SIZE / 3);
   localparam logic [WRAP_W-1:0] TSIZE = WRAP_W'(TABLE_SIZE);

   logic [DIV_W-1:0]   fps_ff,   fps_in;
   logic [SLOT_W-1:0]  slot_ff,  slot_in;
   logic [DIV_W-1:0]   div_ff,   div_in;
   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic [LEVEL_W-1:0] red_ff,   red_in;
   logic [LEVEL_W-1:0] blue_ff,  blue_in;
   logic [LEVEL_W-1:0] green_ff, green_in;

   logic              frame_end;
   logic              advance;
   logic [POS_W-1:0]  pos_next;
   logic [WRAP_W-1:0] sum_b, sum_g, idx_b, idx_g;

   // config register
   assign fps_in = csr_wr_en ? csr_wr_data : fps_ff;

   // slot counter and frame divider
   assign frame_end = step && (slot_ff >= SLOT_W'(PERIOD));
   assign advance   = frame_end && (div_ff >= fps_ff);

   assign slot_in = !step     ? slot_ff :
                    frame_end ? SLOT_W'(1) : slot_ff + SLOT_W'(1);

   assign div_in = !frame_end ? div_ff :
                   advance    ? DIV_W'(1) : div_ff + DIV_W'(1);

   // table position and offset lookups
   assign pos_next = (pos_ff >= POS_W'(TABLE_SIZE - 1)) ? '0 : pos_ff + POS_W'(1);
   assign sum_b    = {1'b0, pos_next} + OFS_B;
   assign sum_g    = {1'b0, pos_next} + OFS_G;
   assign idx_b    = (sum_b >= TSIZE) ? sum_b - TSIZE : sum_b;
   assign idx_g    = (sum_g >= TSIZE) ? sum_g - TSIZE : sum_g;

   assign pos_in   = advance ? pos_next : pos_ff;
   assign red_in   = advance ? rom_at({1'b0, pos_next}) : red_ff;
   assign blue_in  = advance ? rom_at(idx_b) : blue_ff;
   assign green_in = advance ? rom_at(idx_g) : green_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff   <= FPS_RESET;
         slot_ff  <= SLOT_W'(1);
         div_ff   <= '0;
         pos_ff   <= '0;
         red_ff   <= '0;
         blue_ff  <= '0;
         green_ff <= '0;
      end else begin
         fps_ff   <= fps_in;
         slot_ff  <= slot_in;
         div_ff   <= div_in;
         pos_ff   <= pos_in;
         red_ff   <= red_in;
         blue_ff  <= blue_in;
         green_ff <= green_in;
      end
   end

   assign state.slot  = slot_ff;
   assign state.pos   = pos_ff;
   assign state.red   = red_ff;
   assign state.blue  = blue_ff;
   assign state.green = green_ff;

endmodule

`default_nettype wire

// ----- rtl/rgb_sine_color_cycle_pwm.sv -----
// Pipeline: a word accepted sits in the input register, moves to the result
//   register once that register is free and is on rsp_* from then on.
// Throughput: one word per cycle; the input register stalls only while the
//   result register holds a word that the sink stalls.
// Reset: synchronous, active high; counters, levels and config return to
//   their power-up values and both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module rgb_sine_color_cycle_pwm
   import rgbsc_pkg::*;
#(
   parameter int PERIOD     = 100,
   parameter int TABLE_SIZE = 72
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_slot_tick,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_red_on,
   output logic                   rsp_blue_on,
   output logic                   rsp_green_on,
   output logic [SLOT_W-1:0]      rsp_slot_number,
   output logic [POS_W-1:0]       rsp_phase_index,
   input  wire logic              csr_wr_en,
   input  wire logic [DIV_W-1:0]  csr_wr_data
);

   logic req_valid_ff, req_valid_in;
   logic req_tick_ff,  req_tick_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic red_ff, blue_ff, green_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [POS_W-1:0]  pos_ff;

   logic            out_free;
   logic            move;
   phase_state_type state;

   // handshake between the two registers
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   assign req_valid_in = req_stall ? req_valid_ff : req_valid;
   assign req_tick_in  = req_stall ? req_tick_ff  : req_slot_tick;
   assign rsp_valid_in = move ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   rgbsc_phase #(
      .PERIOD     (PERIOD),
      .TABLE_SIZE (TABLE_SIZE)
   ) u_phase (
      .clock       (clock),
      .reset       (reset),
      .step        (move && req_tick_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .state       (state)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_tick_ff <= req_tick_in;
      if (move) begin
         red_ff   <= state.slot <= state.red;
         blue_ff  <= state.slot <= state.blue;
         green_ff <= state.slot <= state.green;
         slot_ff  <= state.slot;
         pos_ff   <= state.pos;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_on      = red_ff;
   assign rsp_blue_on     = blue_ff;
   assign rsp_green_on    = green_ff;
   assign rsp_slot_number = slot_ff;
   assign rsp_phase_index = pos_ff;

endmodule

`default_nettype wire

// ----- tb/sv/rgb_pwm_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the PWM block, keeps its own copy of the slot,
// frame and color-wheel state, and checks every result word in order.
module rgb_pwm_checker
   import rgbsc_pkg::*;
#(
   parameter int PERIOD     = 100,
   parameter int TABLE_SIZE = 72
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic              req_slot_tick,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              rsp_red_on,
   input  wire logic              rsp_blue_on,
   input  wire logic              rsp_green_on,
   input  wire logic [SLOT_W-1:0] rsp_slot_number,
   input  wire logic [POS_W-1:0]  rsp_phase_index,
   input  wire logic              csr_wr_en,
   input  wire logic [DIV_W-1:0]  csr_wr_data,
   output int                     fail_count,
   output int                     pending,
   output int                     checked,
   output int                     wheel_steps
);

   localparam int WHEEL_LEN = 72;
   localparam int BLUE_OFS  = TABLE_SIZE / 3;
   localparam int GREEN_OFS = 2 * TABLE_SIZE / 3;
   localparam int MAX_REPORTS = 40;

   // floor(50 + 50*sin(5 deg * i)), one full turn
   localparam logic [LEVEL_W-1:0] WHEEL_LEVEL [0:WHEEL_LEN-1] = '{
      7'd50, 7'd54, 7'd58, 7'd62, 7'd67, 7'd71, 7'd75, 7'd78, 7'd82,
      7'd85, 7'd88, 7'd90, 7'd93, 7'd95, 7'd96, 7'd98, 7'd99, 7'd99,
      7'd100, 7'd99, 7'd99, 7'd98, 7'd96, 7'd95, 7'd93, 7'd90, 7'd88,
      7'd85, 7'd82, 7'd78, 7'd75, 7'd71, 7'd67, 7'd62, 7'd58, 7'd54,
      7'd50, 7'd45, 7'd41, 7'd37, 7'd32, 7'd28, 7'd25, 7'd21, 7'd17,
      7'd14, 7'd11, 7'd9, 7'd6, 7'd4, 7'd3, 7'd1, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd1, 7'd3, 7'd4, 7'd6, 7'd9, 7'd11,
      7'd14, 7'd17, 7'd21, 7'd25, 7'd28, 7'd32, 7'd37, 7'd41, 7'd45
   };

   typedef struct packed {
      logic              red;
      logic              blue;
      logic              green;
      logic [SLOT_W-1:0] slot;
      logic [POS_W-1:0]  pos;
   } led_word_type;

   // mirrored block state
   logic [DIV_W-1:0]   frames_setting;
   logic [SLOT_W-1:0]  slot_now;
   logic [DIV_W-1:0]   frame_div;
   int                 wheel_pos;
   logic [LEVEL_W-1:0] red_lvl, blue_lvl, green_lvl;

   led_word_type led_expected_q[$];

   function automatic logic [LEVEL_W-1:0] wheel_level_at(input int pos);
      return WHEEL_LEVEL[(pos % TABLE_SIZE) % WHEEL_LEN];
   endfunction

   // one slot word: report the current state, then advance on a tick
   task automatic step_slot(input logic tick, output led_word_type w);
      w.red   = (slot_now <= red_lvl);
      w.blue  = (slot_now <= blue_lvl);
      w.green = (slot_now <= green_lvl);
      w.slot  = slot_now;
      w.pos   = POS_W'(wheel_pos);
      if (tick) begin
         if (int'(slot_now) >= PERIOD) begin
            slot_now = SLOT_W'(1);
            // frame end: either step the wheel or count the frame
            if (frame_div >= frames_setting) begin
               frame_div = DIV_W'(1);
               wheel_pos = (wheel_pos + 1) % TABLE_SIZE;
               red_lvl   = wheel_level_at(wheel_pos);
               blue_lvl  = wheel_level_at(wheel_pos + BLUE_OFS);
               green_lvl = wheel_level_at(wheel_pos + GREEN_OFS);
               wheel_steps++;
            end else begin
               frame_div = frame_div + DIV_W'(1);
            end
         end else begin
            slot_now = slot_now + SLOT_W'(1);
         end
      end
   endtask

   task automatic check_field(input string field, input int want, input int seen);
      if (want != seen) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, field, want, seen);
      end
   endtask

   // sample both channels and the register port at every edge
   always @(posedge clock) begin : watch
      led_word_type want_w;
      if (reset) begin
         frames_setting = FPS_RESET;
         slot_now       = SLOT_W'(1);
         frame_div      = '0;
         wheel_pos      = 0;
         red_lvl        = '0;
         blue_lvl       = '0;
         green_lvl      = '0;
         led_expected_q.delete();
         fail_count     = 0;
         checked        = 0;
         wheel_steps    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (led_expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t ns: result word with nothing expected, slot %0d index %0d",
                           $time, rsp_slot_number, rsp_phase_index);
            end else begin
               want_w = led_expected_q.pop_front();
               check_field("red_on", want_w.red, rsp_red_on);
               check_field("blue_on", want_w.blue, rsp_blue_on);
               check_field("green_on", want_w.green, rsp_green_on);
               check_field("slot_number", want_w.slot, rsp_slot_number);
               check_field("phase_index", want_w.pos, rsp_phase_index);
               checked++;
            end
         end
         if (csr_wr_en)
            frames_setting = csr_wr_data;
         if (req_valid && !req_stall) begin
            step_slot(req_slot_tick, want_w);
            led_expected_q.push_back(want_w);
         end
      end
      pending = led_expected_q.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import rgbsc_pkg::*;

   localparam int PERIOD         = 100;
   localparam int TABLE_SIZE     = 72;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 60;
   localparam int MODE_SPAN      = 400;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic clock;
   logic reset = 1'b1;

   logic              req_valid     = 1'b0;
   logic              req_slot_tick = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic              rsp_red_on, rsp_blue_on, rsp_green_on;
   logic [SLOT_W-1:0] rsp_slot_number;
   logic [POS_W-1:0]  rsp_phase_index;
   logic              csr_wr_en     = 1'b0;
   logic [DIV_W-1:0]  csr_wr_data   = '0;

   int fail_count, pending, checked, wheel_steps;
   int words_sent = 0;
   int settings   = 0;
   int idle_cycles = 0;
   int hold_left  = 0;
   logic hold_start = 1'b0;
   idle_mode_type idle_mode = IDLE_NONE;

   rgb_sine_color_cycle_pwm #(
      .PERIOD     (PERIOD),
      .TABLE_SIZE (TABLE_SIZE)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_slot_tick   (req_slot_tick),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_on      (rsp_red_on),
      .rsp_blue_on     (rsp_blue_on),
      .rsp_green_on    (rsp_green_on),
      .rsp_slot_number (rsp_slot_number),
      .rsp_phase_index (rsp_phase_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   rgb_pwm_checker #(
      .PERIOD     (PERIOD),
      .TABLE_SIZE (TABLE_SIZE)
   ) pwm_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_slot_tick   (req_slot_tick),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_on      (rsp_red_on),
      .rsp_blue_on     (rsp_blue_on),
      .rsp_green_on    (rsp_green_on),
      .rsp_slot_number (rsp_slot_number),
      .rsp_phase_index (rsp_phase_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked         (checked),
      .wheel_steps     (wheel_steps)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int sender_gap_pct();
      case (idle_mode)
         IDLE_SENDER: return 56;
         IDLE_BOTH:   return 17;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 56;
         IDLE_BOTH:     return 17;
         default:       return 0;
      endcase
   endfunction

   // sink side: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left  = LONG_HOLD;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct());
      end
   end

   // watchdog: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: watchdog, no word moved for %0d cycles", $time, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // offer one word, with random gaps ahead of it, and wait for acceptance
   task automatic send_word(input logic tick);
      while ($urandom_range(99) < sender_gap_pct()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_slot_tick <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // stop offering and wait until every expected word has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frames_setting(input logic [DIV_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings++;
   endtask

   // mostly ticks, with idle slots mixed in; idling mode rotates per span
   task automatic run_slots(input int count, input idle_mode_type first_mode);
      for (int n = 0; n < count; n++) begin
         if (n % MODE_SPAN == 0)
            idle_mode = idle_mode_type'((int'(first_mode) + n / MODE_SPAN) % 4);
         send_word($urandom_range(99) < 88);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: idle words at reset state, then ticks and holds mixed
      idle_mode = IDLE_NONE;
      repeat (3) send_word(1'b0);
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b0);
      repeat (6) send_word(1'b1);
      send_word(1'b0);
      repeat (4) send_word(1'b1);
      repeat (2) send_word(1'b0);
      send_word(1'b1);

      // power-up divider setting
      run_slots(250, IDLE_NONE);

      // zero setting: wheel steps every frame
      write_frames_setting(DIV_W'(0));
      run_slots(300, IDLE_SENDER);

      // largest setting, with the sink holding off long enough to back up
      write_frames_setting(DIV_W'(15));
      hold_start = 1'b1;
      run_slots(250, IDLE_RECEIVER);

      write_frames_setting(DIV_W'(1));
      run_slots(250, IDLE_BOTH);

      // zero setting again, starting behind a long hold-off
      write_frames_setting(DIV_W'(0));
      hold_start = 1'b1;
      run_slots(300, IDLE_NONE);

      write_frames_setting(DIV_W'(9));
      run_slots(150, IDLE_SENDER);

      write_frames_setting(DIV_W'(3));
      run_slots(130, IDLE_BOTH);

      drain();
      repeat (8) @(posedge clock);

      $display("Sent %0d slot words, checked %0d results over %0d register writes.",
               words_sent, checked, settings);
      $display("Color wheel stepped %0d times; %0d words still outstanding.",
               wheel_steps, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
